// ===== hw/rtl/md5_pkg.sv =====
// MD5 package: round constants, rotate amounts, message word schedule and queue types.
// No dependencies; md5_message_digest, md5_front and md5_back import it.
package md5_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hEFCDAB89;
	localparam logic [31:0] IV_C = 32'h98BADCFE;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [5:0]  LEN_POS = 6'd56;

	// One request on the input channel.
	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} req_in_t;

	// Queue entry from the front part to the back part.
	typedef enum logic [0:0] {
		REQ_BYTE   = 1'b0,
		REQ_FINISH = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t  kind;
		logic [7:0] data;
	} req_t;

	typedef enum logic [2:0] {
		ST_ABSORB,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] t [64];
		t = '{
			32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
			32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
			32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
			32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
			32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
			32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
			32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
			32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
			32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
			32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
			32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
			32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
			32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
			32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
			32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
			32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
		};
		return t[i];
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] i);
		logic [4:0] r;
		unique case ({i[5:4], i[1:0]})
			4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
			4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
			4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
			4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
		endcase
		return r;
	endfunction

	// Index of the message word used by round i.
	function automatic logic [3:0] word_sel(input logic [5:0] i);
		logic [3:0] g;
		logic [3:0] lo;
		lo = i[3:0];
		unique case (i[5:4])
			2'd0: g = lo;
			2'd1: g = 4'((lo << 2) + lo + 4'd1);
			2'd2: g = 4'((lo << 1) + lo + 4'd5);
			default: g = 4'((lo << 3) - lo);
		endcase
		return g;
	endfunction

endpackage

// ===== hw/rtl/md5_stream_if.sv =====
// Valid/ready channel interface with a generic payload type.
// Depends on nothing; used with types from md5_pkg.
interface md5_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/md5_message_digest.sv =====
// Top level of the MD5 digest block: front queue plus compression back end.
// Depends on md5_pkg, md5_stream_if, md5_front and md5_back.
//
// Usage: in_ch carries requests {mode, data_byte}. Mode 0 absorbs one message
// byte; mode 1 finishes the message. out_ch delivers four digest words after a
// finish, word_index 0 to 3, with last set on the fourth; the digest bytes are
// each word least significant byte first.
// Flow: the back end writes each absorbed byte straight into the block buffer, and
// each full 64-byte block adds 64 rounds on one shared round unit plus a
// fold into the chaining words. A finish takes the padding bytes at one a
// cycle, one or two compressions, then four words of output.
// A two-entry request queue lets the source keep sending while the back end
// compresses, until the queue fills and ready drops.
// Reset clears the queue and loads the initial chaining values; the block
// buffer is not cleared, as each of its bytes is written before a compression uses it.
// If the receiver stalls, the current digest word holds on out_ch and the
// back end waits; the front queue still takes up to two requests.
// After the fourth word, state returns to the start of a new message.
module md5_message_digest
	import md5_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	md5_stream_if.sink   in_ch,
	md5_stream_if.source out_ch
);
	logic q_valid;
	logic q_pop;
	req_t q_head;

	md5_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_valid(q_valid),
		.q_head (q_head),
		.q_pop  (q_pop)
	);

	md5_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_head (q_head),
		.q_pop  (q_pop),
		.out_ch (out_ch)
	);
endmodule

// ===== hw/rtl/md5_front.sv =====
// Front part: accepts input requests, classifies them and queues them.
// Depends on md5_pkg and md5_stream_if.
module md5_front
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	md5_stream_if.sink  in_ch,
	output logic        q_valid,
	output req_t        q_head,
	input  logic        q_pop
);
	// Two-entry queue.
	req_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q].kind <= in_ch.payload.mode ? REQ_FINISH : REQ_BYTE;
			mem_q[wptr_q].data <= in_ch.payload.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (q_pop) rptr_q <= ~rptr_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, q_pop});
		end
	end
endmodule

// ===== hw/rtl/md5_back.sv =====
// Back part: block buffer, padding sequencer, one-round-per-cycle compression and output.
// Depends on md5_pkg and md5_stream_if.
module md5_back
	import md5_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  req_t         q_head,
	output logic         q_pop,
	md5_stream_if.source out_ch
);
	state_t      state_q, state_d;
	logic [31:0] buf_q [16];
	logic [31:0] ch_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic        len_sent_q;
	logic [1:0]  widx_q;

	logic        wr_en;
	logic [7:0]  wr_byte;
	logic        start_cmp;

	logic [31:0] f, t1, rot, wsel;
	logic [4:0]  ra;

	assign wsel = buf_q[word_sel(rnd_q)];
	assign ra = rot_amt(rnd_q);
	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: f = d_q ^ (b_q & (c_q ^ d_q));
			2'd1: f = c_q ^ (d_q & (b_q ^ c_q));
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		t1 = a_q + f + wsel + round_k(rnd_q);
		rot = (t1 << ra) | (t1 >> (6'd32 - {1'b0, ra}));
	end

	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_ch.payload.digest_word = ch_q[widx_q];
	assign out_ch.payload.word_index = widx_q;
	assign out_ch.payload.last = (widx_q == 2'd3);

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		wr_en = 1'b0;
		wr_byte = 8'd0;
		start_cmp = 1'b0;
		unique case (state_q)
			ST_ABSORB: begin
				if (q_valid) begin
					q_pop = 1'b1;
					wr_en = 1'b1;
					wr_byte = (q_head.kind == REQ_FINISH) ? PAD_BYTE : q_head.data;
					if (q_head.kind == REQ_FINISH) begin
						state_d = (fill_q == 6'd63) ? ST_ROUND :
							((fill_q == 6'd55) ? ST_LEN : ST_PAD);
						start_cmp = (fill_q == 6'd63);
					end else if (fill_q == 6'd63) begin
						state_d = ST_ROUND;
						start_cmp = 1'b1;
					end
				end
			end
			ST_PAD: begin
				wr_en = 1'b1;
				if (fill_q == 6'd63) begin
					state_d = ST_ROUND;
					start_cmp = 1'b1;
				end else if (fill_q == 6'd55) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				wr_en = 1'b1;
				wr_byte = len_q[7:0];
				if (fill_q == 6'd63) begin
					state_d = ST_ROUND;
					start_cmp = 1'b1;
				end
			end
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD: begin
				if (!fin_q) state_d = ST_ABSORB;
				else if (len_sent_q) state_d = ST_EMIT;
				else state_d = ST_PAD;
			end
			ST_EMIT: if (out_ch.ready && widx_q == 2'd3) state_d = ST_ABSORB;
			default: state_d = ST_ABSORB;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) buf_q[fill_q[5:2]][8 * fill_q[1:0] +: 8] <= wr_byte;
		if (state_q == ST_LEN) len_q <= {8'd0, len_q[63:8]};
		else if (state_q == ST_ABSORB && q_valid && q_head.kind == REQ_FINISH)
			len_q <= bits_q;
		if (start_cmp) begin
			a_q <= ch_q[0]; b_q <= ch_q[1]; c_q <= ch_q[2]; d_q <= ch_q[3];
		end else if (state_q == ST_ROUND) begin
			a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= rot + b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ABSORB;
			ch_q <= '{IV_A, IV_B, IV_C, IV_D};
			bits_q <= 64'd0;
			fill_q <= 6'd0;
			rnd_q <= 6'd0;
			fin_q <= 1'b0;
			len_sent_q <= 1'b0;
			widx_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (wr_en) fill_q <= fill_q + 6'd1;
			if (state_q == ST_ABSORB && q_valid) begin
				if (q_head.kind == REQ_BYTE) bits_q <= bits_q + 64'd8;
				else fin_q <= 1'b1;
			end
			// Once the length bytes are in the block, the next fold ends the
			// message; a finish whose padding filled the block without them
			// goes on to a second padding block.
			if (state_q == ST_LEN) len_sent_q <= 1'b1;
			if (state_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == ST_FOLD) begin
				ch_q[0] <= ch_q[0] + a_q; ch_q[1] <= ch_q[1] + b_q;
				ch_q[2] <= ch_q[2] + c_q; ch_q[3] <= ch_q[3] + d_q;
			end
			if (state_q == ST_EMIT && out_ch.ready) begin
				widx_q <= widx_q + 2'd1;
				if (widx_q == 2'd3) begin
					ch_q <= '{IV_A, IV_B, IV_C, IV_D};
					bits_q <= 64'd0;
					fill_q <= 6'd0;
					fin_q <= 1'b0;
					len_sent_q <= 1'b0;
				end
			end
		end
	end
endmodule
